>>> hdl/i2crm_pkg.sv
// Shared types and constants of the I2C register master.
// Used by the cfg, seq, skid and top-level modules; depends on nothing.
`default_nettype none

package i2crm_pkg;

	// Request codes on req_type
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_PHASE_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_HOLD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_WAIT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT     = 3'd4;

	// Register reset values
	localparam logic [7:0] RST_PHASE_TICKS     = 8'd10;
	localparam logic [7:0] RST_ACK_PHASE_TICKS = 8'd6;
	localparam logic [7:0] RST_SAMPLE_HOLD     = 8'd5;
	localparam logic [7:0] RST_READ_WAIT       = 8'd50;
	localparam logic [7:0] RST_ACK_TIMEOUT     = 8'd250;

	// Bus sequencer phases, one-hot
	typedef enum logic [16:0] {
		PH_IDLE      = 17'b00000000000000001,
		PH_START_A   = 17'b00000000000000010,
		PH_START_B   = 17'b00000000000000100,
		PH_TX_LOW1   = 17'b00000000000001000,
		PH_TX_HIGH   = 17'b00000000000010000,
		PH_TX_LOW2   = 17'b00000000000100000,
		PH_ACK_REL   = 17'b00000000001000000,
		PH_ACK_HIGH  = 17'b00000000010000000,
		PH_ACK_WAIT  = 17'b00000000100000000,
		PH_RD_WAIT   = 17'b00000001000000000,
		PH_RX_LOW    = 17'b00000010000000000,
		PH_RX_HIGH   = 17'b00000100000000000,
		PH_NACK_LOW  = 17'b00001000000000000,
		PH_NACK_HIGH = 17'b00010000000000000,
		PH_STOP_A    = 17'b00100000000000000,
		PH_STOP_B    = 17'b01000000000000000,
		PH_RS_LOW    = 17'b10000000000000000
	} phase_t;

	// Timing configuration seen by the sequencer
	typedef struct packed {
		logic [7:0] phase_ticks;
		logic [7:0] ack_phase_ticks;
		logic [7:0] sample_hold_ticks;
		logic [7:0] read_wait_ticks;
		logic [7:0] ack_timeout;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive_en;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_error;
	} res_t;

endpackage

`default_nettype wire

>>> hdl/i2crm_cfg.sv
// Timing configuration registers of the I2C register master.
// Depends on i2crm_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module i2crm_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [i2crm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                     cfg_data,
	output i2crm_pkg::cfg_t                     cfg
);

	i2crm_pkg::cfg_t cfg_q;

	// Write the addressed register; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_ticks       <= i2crm_pkg::RST_PHASE_TICKS;
			cfg_q.ack_phase_ticks   <= i2crm_pkg::RST_ACK_PHASE_TICKS;
			cfg_q.sample_hold_ticks <= i2crm_pkg::RST_SAMPLE_HOLD;
			cfg_q.read_wait_ticks   <= i2crm_pkg::RST_READ_WAIT;
			cfg_q.ack_timeout       <= i2crm_pkg::RST_ACK_TIMEOUT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				i2crm_pkg::CFG_PHASE_TICKS:     cfg_q.phase_ticks       <= cfg_data;
				i2crm_pkg::CFG_ACK_PHASE_TICKS: cfg_q.ack_phase_ticks   <= cfg_data;
				i2crm_pkg::CFG_SAMPLE_HOLD:     cfg_q.sample_hold_ticks <= cfg_data;
				i2crm_pkg::CFG_READ_WAIT:       cfg_q.read_wait_ticks   <= cfg_data;
				i2crm_pkg::CFG_ACK_TIMEOUT:     cfg_q.ack_timeout       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hdl/i2crm_seq.sv
// Bus sequencer of the I2C register master: transaction state and line levels.
// Advances one tick per accepted request. Depends on i2crm_pkg.
`default_nettype none

module i2crm_seq (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire i2crm_pkg::cfg_t cfg,
	input  wire logic       tick,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] dev_addr,
	input  wire logic [7:0] reg_addr,
	input  wire logic [7:0] wr_data,
	input  wire logic       sda_in,
	output i2crm_pkg::res_t res
);

	i2crm_pkg::phase_t phase_q, phase_d;
	logic [7:0] tick_q, tick_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] dev_q, dev_d;
	logic [7:0] reg_q, reg_d;
	logic [7:0] data_q, data_d;
	logic       is_read_q, is_read_d;
	logic [7:0] last_q, last_d;
	logic       err_q, err_d;
	logic [1:0] bidx_q, bidx_d;
	logic       done;

	logic [7:0] len;
	logic [8:0] tick_inc;
	logic       fin;
	logic [7:0] tick_el;
	logic [3:0] bit_inc;

	// Pick the length of the current timed phase
	always_comb begin
		case (phase_q)
			i2crm_pkg::PH_ACK_REL,
			i2crm_pkg::PH_ACK_HIGH: len = cfg.ack_phase_ticks;
			i2crm_pkg::PH_RD_WAIT:  len = cfg.read_wait_ticks;
			i2crm_pkg::PH_RX_HIGH:  len = cfg.sample_hold_ticks;
			default:                len = cfg.phase_ticks;
		endcase
	end

	// Count one tick of a timed phase
	assign tick_inc = {1'b0, tick_q} + 9'd1;
	assign fin      = tick_inc >= {1'b0, len};
	assign tick_el  = fin ? 8'd0 : tick_inc[7:0];
	assign bit_inc  = bit_q + 4'd1;

	// Next state for one tick
	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		dev_d     = dev_q;
		reg_d     = reg_q;
		data_d    = data_q;
		is_read_d = is_read_q;
		last_d    = last_q;
		err_d     = err_q;
		bidx_d    = bidx_q;
		done      = 1'b0;
		case (phase_q)
			i2crm_pkg::PH_IDLE: begin
				if (req_type == i2crm_pkg::REQ_WRITE || req_type == i2crm_pkg::REQ_READ) begin
					dev_d     = dev_addr;
					reg_d     = reg_addr;
					data_d    = wr_data;
					is_read_d = (req_type == i2crm_pkg::REQ_READ);
					err_d     = 1'b0;
					bidx_d    = 2'd0;
					phase_d   = i2crm_pkg::PH_START_A;
					tick_d    = 8'd0;
				end
			end
			i2crm_pkg::PH_RS_LOW: begin
				tick_d = tick_el;
				if (fin) phase_d = i2crm_pkg::PH_START_A;
			end
			i2crm_pkg::PH_START_A: begin
				tick_d = tick_el;
				if (fin) phase_d = i2crm_pkg::PH_START_B;
			end
			i2crm_pkg::PH_START_B: begin
				tick_d = tick_el;
				if (fin) begin
					shift_d = (bidx_q == 2'd0) ? dev_q : dev_q + 8'd1;
					bit_d   = 4'd0;
					phase_d = i2crm_pkg::PH_TX_LOW1;
				end
			end
			i2crm_pkg::PH_TX_LOW1: begin
				tick_d = tick_el;
				if (fin) phase_d = i2crm_pkg::PH_TX_HIGH;
			end
			i2crm_pkg::PH_TX_HIGH: begin
				tick_d = tick_el;
				if (fin) phase_d = i2crm_pkg::PH_TX_LOW2;
			end
			i2crm_pkg::PH_TX_LOW2: begin
				tick_d = tick_el;
				if (fin) begin
					shift_d = {shift_q[6:0], 1'b0};
					bit_d   = bit_inc;
					phase_d = (bit_inc >= 4'd8) ? i2crm_pkg::PH_ACK_REL
					                            : i2crm_pkg::PH_TX_LOW1;
				end
			end
			i2crm_pkg::PH_ACK_REL: begin
				tick_d = tick_el;
				if (fin) phase_d = i2crm_pkg::PH_ACK_HIGH;
			end
			i2crm_pkg::PH_ACK_HIGH: begin
				tick_d = tick_el;
				if (fin) phase_d = i2crm_pkg::PH_ACK_WAIT;
			end
			i2crm_pkg::PH_ACK_WAIT: begin
				if (!sda_in) begin
					// Acknowledged: pick the next byte or step
					tick_d = 8'd0;
					if (bidx_q == 2'd0) begin
						bidx_d  = 2'd1;
						shift_d = reg_q;
						bit_d   = 4'd0;
						phase_d = i2crm_pkg::PH_TX_LOW1;
					end else if (bidx_q == 2'd1) begin
						bidx_d = 2'd2;
						if (is_read_q) begin
							phase_d = i2crm_pkg::PH_RS_LOW;
						end else begin
							shift_d = data_q;
							bit_d   = 4'd0;
							phase_d = i2crm_pkg::PH_TX_LOW1;
						end
					end else if (bidx_q == 2'd2 && is_read_q) begin
						if (cfg.read_wait_ticks == 8'd0) begin
							shift_d = 8'd0;
							bit_d   = 4'd0;
							phase_d = i2crm_pkg::PH_RX_LOW;
						end else begin
							phase_d = i2crm_pkg::PH_RD_WAIT;
						end
					end else begin
						phase_d = i2crm_pkg::PH_STOP_A;
					end
				end else if (tick_inc > {1'b0, cfg.ack_timeout}) begin
					// No acknowledge in time: abort through STOP
					err_d   = 1'b1;
					phase_d = i2crm_pkg::PH_STOP_A;
					tick_d  = 8'd0;
				end else begin
					tick_d = tick_inc[7:0];
				end
			end
			i2crm_pkg::PH_RD_WAIT: begin
				tick_d = tick_el;
				if (fin) begin
					shift_d = 8'd0;
					bit_d   = 4'd0;
					phase_d = i2crm_pkg::PH_RX_LOW;
				end
			end
			i2crm_pkg::PH_RX_LOW: begin
				tick_d = tick_el;
				if (fin) phase_d = i2crm_pkg::PH_RX_HIGH;
			end
			i2crm_pkg::PH_RX_HIGH: begin
				// Sample on the first tick of the high phase
				if (tick_q == 8'd0) begin
					shift_d = {shift_q[6:0], sda_in};
					bit_d   = bit_inc;
				end
				tick_d = tick_el;
				if (fin) begin
					phase_d = (bit_d >= 4'd8) ? i2crm_pkg::PH_NACK_LOW
					                          : i2crm_pkg::PH_RX_LOW;
				end
			end
			i2crm_pkg::PH_NACK_LOW: begin
				tick_d = tick_el;
				if (fin) phase_d = i2crm_pkg::PH_NACK_HIGH;
			end
			i2crm_pkg::PH_NACK_HIGH: begin
				tick_d = tick_el;
				if (fin) begin
					last_d  = shift_q;
					phase_d = i2crm_pkg::PH_STOP_A;
				end
			end
			i2crm_pkg::PH_STOP_A: begin
				tick_d = tick_el;
				if (fin) phase_d = i2crm_pkg::PH_STOP_B;
			end
			i2crm_pkg::PH_STOP_B: begin
				tick_d = tick_el;
				if (fin) begin
					phase_d = i2crm_pkg::PH_IDLE;
					done    = 1'b1;
				end
			end
			default: begin
				phase_d = i2crm_pkg::PH_IDLE;
				tick_d  = 8'd0;
			end
		endcase
	end

	// Drive line levels from the phase after this tick
	always_comb begin
		res.busy_res  = (phase_d != i2crm_pkg::PH_IDLE);
		res.done_res  = done;
		res.read_data = last_d;
		res.ack_error = err_d;
		case (phase_d)
			i2crm_pkg::PH_START_A: begin
				res.scl_out = 1'b1; res.sda_out = 1'b1; res.sda_drive_en = 1'b1;
			end
			i2crm_pkg::PH_START_B: begin
				res.scl_out = 1'b1; res.sda_out = 1'b0; res.sda_drive_en = 1'b1;
			end
			i2crm_pkg::PH_TX_LOW1,
			i2crm_pkg::PH_TX_LOW2: begin
				res.scl_out = 1'b0; res.sda_out = shift_d[7]; res.sda_drive_en = 1'b1;
			end
			i2crm_pkg::PH_TX_HIGH: begin
				res.scl_out = 1'b1; res.sda_out = shift_d[7]; res.sda_drive_en = 1'b1;
			end
			i2crm_pkg::PH_ACK_REL,
			i2crm_pkg::PH_RD_WAIT,
			i2crm_pkg::PH_RX_LOW: begin
				res.scl_out = 1'b0; res.sda_out = 1'b1; res.sda_drive_en = 1'b0;
			end
			i2crm_pkg::PH_ACK_HIGH,
			i2crm_pkg::PH_ACK_WAIT,
			i2crm_pkg::PH_RX_HIGH: begin
				res.scl_out = 1'b1; res.sda_out = 1'b1; res.sda_drive_en = 1'b0;
			end
			i2crm_pkg::PH_NACK_LOW,
			i2crm_pkg::PH_RS_LOW: begin
				res.scl_out = 1'b0; res.sda_out = 1'b1; res.sda_drive_en = 1'b1;
			end
			i2crm_pkg::PH_STOP_A: begin
				res.scl_out = 1'b0; res.sda_out = 1'b0; res.sda_drive_en = 1'b1;
			end
			default: begin
				res.scl_out = 1'b1; res.sda_out = 1'b1; res.sda_drive_en = 1'b1;
			end
		endcase
	end

	// Commit the tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= i2crm_pkg::PH_IDLE;
			tick_q    <= 8'd0;
			bit_q     <= 4'd0;
			shift_q   <= 8'd0;
			dev_q     <= 8'd0;
			reg_q     <= 8'd0;
			data_q    <= 8'd0;
			is_read_q <= 1'b0;
			last_q    <= 8'd0;
			err_q     <= 1'b0;
			bidx_q    <= 2'd0;
		end else if (tick) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			dev_q     <= dev_d;
			reg_q     <= reg_d;
			data_q    <= data_d;
			is_read_q <= is_read_d;
			last_q    <= last_d;
			err_q     <= err_d;
			bidx_q    <= bidx_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/i2crm_skid.sv
// Two-entry result buffer: output register plus skid register.
// Decouples request stall from result stall. Depends on i2crm_pkg.
`default_nettype none

module i2crm_skid (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire i2crm_pkg::res_t push_data,
	output logic            full,
	output logic            out_valid,
	input  wire logic       out_stall,
	output i2crm_pkg::res_t out_data
);

	logic            main_v_q;
	logic            skid_v_q;
	i2crm_pkg::res_t main_q;
	i2crm_pkg::res_t skid_q;
	logic            pop;

	assign pop = main_v_q && !out_stall;

	// Hold control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || pop) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Move results: skid drains into main first
	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

endmodule

`default_nettype wire

>>> hdl/i2c_register_master_top.sv
// I2C register master: timing ticks in, bus line levels and status out.
// Instantiates i2crm_cfg, i2crm_seq and i2crm_skid; uses i2crm_pkg.
//
// Each request on the input channel (in_valid/in_stall) is one timing tick
// carrying the sampled SDA level and, when idle, an optional register write
// or read request. For every request exactly one result leaves on the output
// channel (out_valid/out_stall): SCL/SDA levels, SDA drive enable, busy,
// done pulse, last read byte and acknowledge error flag.
// The result of a request is registered in the output register, or in the
// skid entry while the output stalls; one request per cycle is sustained
// while out_stall is low, set by the single sequencer state update per tick.
// When the receiver stalls, one more request is taken into the skid entry,
// then in_stall rises until the output register drains.
// Reset (arst_n low) returns the bus to idle with both lines high, empties
// the result buffer and loads the timing registers with their defaults.
// The user writes timing registers through cfg_wr_en/cfg_index/cfg_data
// while no transaction is in progress; the block does not enforce this.
`default_nettype none

module i2c_register_master_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [i2crm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     req_type,
	input  wire logic [7:0]                     dev_addr,
	input  wire logic [7:0]                     reg_addr,
	input  wire logic [7:0]                     wr_data,
	input  wire logic                           sda_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                scl_out,
	output logic                                sda_out,
	output logic                                sda_drive_en,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [7:0]                          read_data,
	output logic                                ack_error
);

	i2crm_pkg::cfg_t cfg;
	i2crm_pkg::res_t res;
	i2crm_pkg::res_t out_data;
	logic            full;
	logic            in_fire;

	assign in_stall = full;
	assign in_fire  = in_valid && !full;

	i2crm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2crm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.tick     (in_fire),
		.req_type (req_type),
		.dev_addr (dev_addr),
		.reg_addr (reg_addr),
		.wr_data  (wr_data),
		.sda_in   (sda_in),
		.res      (res)
	);

	i2crm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Unpack the result onto its ports
	assign scl_out      = out_data.scl_out;
	assign sda_out      = out_data.sda_out;
	assign sda_drive_en = out_data.sda_drive_en;
	assign busy_res     = out_data.busy_res;
	assign done_res     = out_data.done_res;
	assign read_data    = out_data.read_data;
	assign ack_error    = out_data.ack_error;

endmodule

`default_nettype wire

>>> hdl/i2crm_checker.sv
// Port-level checks of the I2C register master, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module i2crm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       scl_out,
	input wire logic       sda_out,
	input wire logic       sda_drive_en,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic [7:0] read_data
);

	// Done pulses only as the bus returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done pulse while still busy");

	// Idle bus drives both lines high
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> scl_out && sda_out && sda_drive_en)
		else $error("idle bus not released high");

	// Released SDA reads as high
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sda_drive_en |-> sda_out && busy_res)
		else $error("SDA released with low level or outside a transaction");

	// Stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(scl_out))
		else $error("stalled result changed");

endmodule

bind i2c_register_master_top i2crm_checker u_i2crm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.scl_out      (scl_out),
	.sda_out      (sda_out),
	.sda_drive_en (sda_drive_en),
	.busy_res     (busy_res),
	.done_res     (done_res),
	.read_data    (read_data)
);

`default_nettype wire
